[hw/rtl/bitmap_layer_palette_scanout_top_defines.svh]
// Assertion macros for the bitmap layer scanout block.
// Used by the port checker; depends on nothing else.
`ifndef BITMAP_LAYER_PALETTE_SCANOUT_TOP_DEFINES_SVH
`define BITMAP_LAYER_PALETTE_SCANOUT_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define BLPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define BLPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/blps_pkg.sv]
// Shared types, codes and helpers of the bitmap layer scanout block.
// No dependencies.
package blps_pkg;

  localparam int FB_ADDR_BITS_DEF = 20;
  localparam int PAL_DEPTH        = 256;
  localparam int PAL_AW           = $clog2(PAL_DEPTH);
  localparam int PAL_DW           = 12;

  // Opcodes
  localparam logic [2:0] OP_REG_WRITE = 3'd0;
  localparam logic [2:0] OP_REG_READ  = 3'd1;
  localparam logic [2:0] OP_FRAME     = 3'd2;
  localparam logic [2:0] OP_PIX_ADDR  = 3'd3;
  localparam logic [2:0] OP_PIX_COLOR = 3'd4;

  // Register window
  localparam logic [3:0] REG_CTRL    = 4'd0;
  localparam logic [3:0] REG_ID      = 4'd1;
  localparam logic [3:0] REG_BASE_LO = 4'd2;
  localparam logic [3:0] REG_BASE_MD = 4'd3;
  localparam logic [3:0] REG_BASE_HI = 4'd4;
  localparam logic [3:0] REG_CURSOR  = 4'd6;
  localparam logic [3:0] REG_PAL_LO  = 4'd7;
  localparam logic [3:0] REG_PAL_HI  = 4'd8;

  localparam logic [7:0] ID_VALUE     = 8'hB5;
  localparam logic [7:0] BASE_LO_MASK = 8'hFE;
  localparam logic [1:0] MODE_8BPP    = 2'd1;
  localparam logic [1:0] MODE_ALT     = 2'd2;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] addr;
    logic [PAL_DW-1:0] data;
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
  } pal_rd_t;

  function automatic logic [7:0] expand_nibble(input logic [3:0] n);
    return {n, n};
  endfunction

endpackage

[hw/rtl/blps_pal_mem.sv]
// Palette store: 256 x 12 synchronous RAM with a registered read.
// Valid bits give the all-zero reset contents. Depends on blps_pkg.
module blps_pal_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  blps_pkg::pal_wr_t             wr,
  input  blps_pkg::pal_rd_t             rd,
  output logic [blps_pkg::PAL_DW-1:0]   rd_data
);

  logic [blps_pkg::PAL_DW-1:0]    mem [blps_pkg::PAL_DEPTH];
  logic [blps_pkg::PAL_DEPTH-1:0] valid;
  logic [blps_pkg::PAL_DW-1:0]    rd_q;
  logic                           rd_valid;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_q <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_valid <= valid[rd.addr];
      end
    end
  end

  // Never-written entries read as zero
  assign rd_data = rd_valid ? rd_q : '0;

endmodule

[hw/rtl/blps_ctrl.sv]
// Register window, config port, offset math and result stage.
// Drives the palette RAM ports. Depends on blps_pkg.
module blps_ctrl #(
  parameter int FB_ADDR_BITS = blps_pkg::FB_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [2:0]                  opcode,
  input  logic [3:0]                  reg_index,
  input  logic [7:0]                  write_data,
  input  logic [9:0]                  pixel_x,
  input  logic [8:0]                  pixel_y,
  input  logic [7:0]                  fetched_byte,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output blps_pkg::pal_wr_t           pal_wr,
  output blps_pkg::pal_rd_t           pal_rd,
  input  logic [blps_pkg::PAL_DW-1:0] pal_data,
  output logic                        done,
  output logic [7:0]                  read_data,
  output logic [19:0]                 fb_offset,
  output logic [23:0]                 rgb,
  output logic                        layer_active,
  output logic                        passthrough
);

  localparam int SUM_W = 21;

  logic        master_switch;
  logic        enable_bit, enable_bit_next;
  logic [1:0]  mode_field, mode_field_next;
  logic        passthrough_bit, passthrough_bit_next;
  logic [19:0] display_base, display_base_next;
  logic [19:0] latched_base;
  logic [7:0]  palette_low_hold, palette_low_hold_next;
  logic [7:0]  palette_cursor, palette_cursor_next;

  logic             is_write, is_read, is_frame, is_addr, is_color;
  logic [7:0]       rd_value;
  logic [SUM_W-1:0] row_off, col_off, sum, wrap_mask;
  logic [7:0]       pal_index;
  logic             color_q;

  assign is_write = accept && (opcode == blps_pkg::OP_REG_WRITE);
  assign is_read  = accept && (opcode == blps_pkg::OP_REG_READ);
  assign is_frame = accept && (opcode == blps_pkg::OP_FRAME);
  assign is_addr  = accept && (opcode == blps_pkg::OP_PIX_ADDR);
  assign is_color = accept && (opcode == blps_pkg::OP_PIX_COLOR);

  // Config port
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, master_switch} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_switch <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      master_switch <= pwdata[0];
    end
  end

  // Register writes
  always_comb begin
    enable_bit_next       = enable_bit;
    mode_field_next       = mode_field;
    passthrough_bit_next  = passthrough_bit;
    display_base_next     = display_base;
    palette_low_hold_next = palette_low_hold;
    palette_cursor_next   = palette_cursor;
    pal_wr.we             = 1'b0;
    pal_wr.addr           = palette_cursor;
    pal_wr.data           = {write_data[3:0], palette_low_hold};
    if (is_write) begin
      case (reg_index)
        blps_pkg::REG_CTRL: begin
          enable_bit_next      = write_data[0];
          mode_field_next      = write_data[2:1];
          passthrough_bit_next = write_data[3];
        end
        blps_pkg::REG_BASE_LO: display_base_next[7:0] = write_data & blps_pkg::BASE_LO_MASK;
        blps_pkg::REG_BASE_MD: display_base_next[15:8] = write_data;
        blps_pkg::REG_BASE_HI: display_base_next[19:16] = write_data[3:0];
        blps_pkg::REG_CURSOR:  palette_cursor_next = write_data;
        blps_pkg::REG_PAL_LO:  palette_low_hold_next = write_data;
        blps_pkg::REG_PAL_HI: begin
          pal_wr.we           = 1'b1;
          palette_cursor_next = palette_cursor + 8'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_bit       <= 1'b0;
      mode_field       <= 2'd0;
      passthrough_bit  <= 1'b0;
      display_base     <= '0;
      latched_base     <= '0;
      palette_low_hold <= '0;
      palette_cursor   <= '0;
    end else begin
      enable_bit       <= enable_bit_next;
      mode_field       <= mode_field_next;
      passthrough_bit  <= passthrough_bit_next;
      display_base     <= display_base_next;
      palette_low_hold <= palette_low_hold_next;
      palette_cursor   <= palette_cursor_next;
      if (is_frame) begin
        latched_base <= display_base;
      end
    end
  end

  // Register reads
  always_comb begin
    case (reg_index)
      blps_pkg::REG_CTRL:    rd_value = {4'b0, passthrough_bit, mode_field, enable_bit};
      blps_pkg::REG_ID:      rd_value = master_switch ? blps_pkg::ID_VALUE : 8'h00;
      blps_pkg::REG_BASE_LO: rd_value = display_base[7:0];
      blps_pkg::REG_BASE_MD: rd_value = display_base[15:8];
      blps_pkg::REG_BASE_HI: rd_value = {4'b0, display_base[19:16]};
      default:               rd_value = 8'h00;
    endcase
  end

  // Offset: pitch 640 is y<<9 + y<<7, pitch 320 is y<<8 + y<<6
  always_comb begin
    if (mode_field == blps_pkg::MODE_8BPP) begin
      row_off = {3'b0, pixel_y, 9'b0} + {5'b0, pixel_y, 7'b0};
      col_off = {11'b0, pixel_x};
    end else begin
      row_off = {4'b0, pixel_y, 8'b0} + {6'b0, pixel_y, 6'b0};
      col_off = {12'b0, pixel_x[9:1]};
    end
    sum = {1'b0, latched_base} + row_off + col_off;
    for (int i = 0; i < SUM_W; i++) begin
      wrap_mask[i] = (i < FB_ADDR_BITS);
    end
  end

  // Palette index from the fetched byte
  always_comb begin
    if (mode_field == blps_pkg::MODE_8BPP) begin
      pal_index = fetched_byte;
    end else if (pixel_x[0]) begin
      pal_index = {4'b0, fetched_byte[3:0]};
    end else begin
      pal_index = {4'b0, fetched_byte[7:4]};
    end
  end

  assign pal_rd.en   = is_color;
  assign pal_rd.addr = pal_index;

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      color_q <= 1'b0;
    end else begin
      done    <= accept;
      color_q <= is_color;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data    <= is_read ? rd_value : 8'h00;
      fb_offset    <= is_addr ? sum[19:0] & wrap_mask[19:0] : 20'h0;
      layer_active <= master_switch && enable_bit_next &&
                      ((mode_field_next == blps_pkg::MODE_8BPP) ||
                       (mode_field_next == blps_pkg::MODE_ALT));
      passthrough  <= passthrough_bit_next;
    end
  end

  assign rgb = color_q ? {blps_pkg::expand_nibble(pal_data[11:8]),
                          blps_pkg::expand_nibble(pal_data[7:4]),
                          blps_pkg::expand_nibble(pal_data[3:0])} : 24'h0;

endmodule

[hw/rtl/bitmap_layer_palette_scanout_top.sv]
// Top level of the bitmap layer scanout block.
// Instantiates blps_ctrl and blps_pal_mem; depends on blps_pkg.
//
// Usage:
//   Items enter on start with opcode, reg_index, write_data, pixel_x,
//   pixel_y and fetched_byte; an item is taken whenever start is high and
//   busy is low. busy stays low: the block takes one item every cycle.
//   Each item gives one result on read_data, fb_offset, rgb, layer_active
//   and passthrough, marked by done for one cycle, in the cycle after the
//   item was taken. Results come out in item order.
//   The palette RAM read is registered: a pixel colour item reads the
//   palette at the accept edge and expands the entry as it leaves.
//   A palette write lands at its accept edge, so a colour item in the next
//   cycle already sees it. The receiver cannot stall; done is a pure
//   strobe and must be sampled. master_switch sits at APB address 0 and is
//   to be written by the user only while idle, not enforced by the block.
//   Reset (rst, synchronous) clears all control registers, the switch and
//   the palette valid bits, so every palette entry reads as zero at once;
//   no clearing pass is needed.
module bitmap_layer_palette_scanout_top #(
  parameter int FB_ADDR_BITS = blps_pkg::FB_ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [3:0]  reg_index,
  input  logic [7:0]  write_data,
  input  logic [9:0]  pixel_x,
  input  logic [8:0]  pixel_y,
  input  logic [7:0]  fetched_byte,
  output logic        done,
  output logic [7:0]  read_data,
  output logic [19:0] fb_offset,
  output logic [23:0] rgb,
  output logic        layer_active,
  output logic        passthrough,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  blps_pkg::pal_wr_t           pal_wr;
  blps_pkg::pal_rd_t           pal_rd;
  logic [blps_pkg::PAL_DW-1:0] pal_data;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  blps_ctrl #(
    .FB_ADDR_BITS(FB_ADDR_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (start && !busy),
    .opcode       (opcode),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .fetched_byte (fetched_byte),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pal_wr       (pal_wr),
    .pal_rd       (pal_rd),
    .pal_data     (pal_data),
    .done         (done),
    .read_data    (read_data),
    .fb_offset    (fb_offset),
    .rgb          (rgb),
    .layer_active (layer_active),
    .passthrough  (passthrough)
  );

  blps_pal_mem u_pal (
    .clk     (clk),
    .rst     (rst),
    .wr      (pal_wr),
    .rd      (pal_rd),
    .rd_data (pal_data)
  );

endmodule

[hw/rtl/blps_checker.sv]
// Port-level checker for the bitmap layer scanout block, bound to the top.
// Depends on blps_pkg and the assertion macro header.
`include "bitmap_layer_palette_scanout_top_defines.svh"

module blps_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [2:0]  opcode,
  input logic        done,
  input logic [7:0]  read_data,
  input logic [19:0] fb_offset,
  input logic [23:0] rgb
);

  `BLPS_ASSERT_NEXT(a_done_follows, clk, rst, start && !busy, done, "item gave no result")
  `BLPS_ASSERT_NEXT(a_no_spurious, clk, rst, !(start && !busy), !done, "result without item")
  `BLPS_ASSERT_NOW(a_rgb_src, clk, rst, done && (rgb != 24'h0), $past(opcode) == blps_pkg::OP_PIX_COLOR, "rgb on non-colour item")
  `BLPS_ASSERT_NOW(a_off_src, clk, rst, done && (fb_offset != 20'h0), $past(opcode) == blps_pkg::OP_PIX_ADDR, "offset on non-address item")
  `BLPS_ASSERT_NOW(a_rd_src, clk, rst, done && (read_data != 8'h0), $past(opcode) == blps_pkg::OP_REG_READ, "read data on non-read item")

endmodule

bind bitmap_layer_palette_scanout_top blps_checker u_blps_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .opcode    (opcode),
  .done      (done),
  .read_data (read_data),
  .fb_offset (fb_offset),
  .rgb       (rgb)
);

[bench/tb.sv]
// Self-checking bench for bitmap_layer_palette_scanout_top: command items, strobed results.
// A scoreboard class predicts each result from the block's register and palette state.
// Depends on blps_pkg and the RTL of the block only.
module tb;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [3:0] REG_RSVD    = 4'd5;
  localparam logic [3:0] REG_LAST    = 4'd15;
  localparam logic [2:0] ADDR_SWITCH = 3'd0;
  localparam int         RAND_ITEMS  = 200;

  typedef struct packed {
    logic [7:0]  rd;
    logic [19:0] off;
    logic [23:0] color;
    logic        active;
    logic        pass;
  } scan_result_t;

  class scanout_scoreboard;
    logic        sw;
    logic        en;
    logic [1:0]  mode;
    logic        pass;
    logic [19:0] base;
    logic [19:0] latched;
    logic [7:0]  low_hold;
    logic [7:0]  cursor;
    logic [11:0] pal [blps_pkg::PAL_DEPTH];
    scan_result_t pending_q [$];
    int errors;
    int checked;

    function new();
      sw = 0; en = 0; mode = 0; pass = 0;
      base = 0; latched = 0; low_hold = 0; cursor = 0;
      errors = 0; checked = 0;
      foreach (pal[i]) pal[i] = '0;
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function void set_switch(logic v);
      sw = v;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function logic [7:0] read_reg(logic [3:0] r);
      case (r)
        blps_pkg::REG_CTRL:    return {4'b0, pass, mode, en};
        blps_pkg::REG_ID:      return sw ? blps_pkg::ID_VALUE : 8'h00;
        blps_pkg::REG_BASE_LO: return base[7:0];
        blps_pkg::REG_BASE_MD: return base[15:8];
        blps_pkg::REG_BASE_HI: return {4'b0, base[19:16]};
        default:               return 8'h00;
      endcase
    endfunction

    function void write_reg(logic [3:0] r, logic [7:0] v);
      case (r)
        blps_pkg::REG_CTRL: begin
          en = v[0];
          mode = v[2:1];
          pass = v[3];
        end
        blps_pkg::REG_BASE_LO: base[7:0] = v & blps_pkg::BASE_LO_MASK;
        blps_pkg::REG_BASE_MD: base[15:8] = v;
        blps_pkg::REG_BASE_HI: base[19:16] = v[3:0];
        blps_pkg::REG_CURSOR:  cursor = v;
        blps_pkg::REG_PAL_LO:  low_hold = v;
        blps_pkg::REG_PAL_HI: begin
          pal[cursor] = {v[3:0], low_hold};
          cursor = cursor + 8'd1;
        end
        default: ;
      endcase
    endfunction

    function void note_item(logic [2:0] op, logic [3:0] r, logic [7:0] wd,
                            logic [9:0] x, logic [8:0] y, logic [7:0] fb);
      scan_result_t res;
      logic [31:0] sum;
      logic [7:0]  idx;
      logic [11:0] e;
      res = '0;
      case (op)
        blps_pkg::OP_REG_WRITE: write_reg(r, wd);
        blps_pkg::OP_REG_READ:  res.rd = read_reg(r);
        blps_pkg::OP_FRAME:     latched = base;
        blps_pkg::OP_PIX_ADDR: begin
          if (mode == blps_pkg::MODE_8BPP) sum = latched + y * 32'd640 + x;
          else sum = latched + y * 32'd320 + (x >> 1);
          sum = sum & ((32'd1 << blps_pkg::FB_ADDR_BITS_DEF) - 32'd1);
          res.off = sum[19:0];
        end
        blps_pkg::OP_PIX_COLOR: begin
          if (mode == blps_pkg::MODE_8BPP) idx = fb;
          else idx = x[0] ? {4'b0, fb[3:0]} : {4'b0, fb[7:4]};
          e = pal[idx];
          res.color = {e[11:8], e[11:8], e[7:4], e[7:4], e[3:0], e[3:0]};
        end
        default: ;
      endcase
      res.active = sw && en && (mode == blps_pkg::MODE_8BPP || mode == blps_pkg::MODE_ALT);
      res.pass = pass;
      pending_q.push_back(res);
    endfunction

    function void check_result(scan_result_t got);
      scan_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result with nothing outstanding: %h", got));
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.rd !== want.rd)
        report($sformatf("read_data %h, want %h", got.rd, want.rd));
      if (got.off !== want.off)
        report($sformatf("fb_offset %h, want %h", got.off, want.off));
      if (got.color !== want.color)
        report($sformatf("rgb %h, want %h", got.color, want.color));
      if (got.active !== want.active)
        report($sformatf("layer_active %b, want %b", got.active, want.active));
      if (got.pass !== want.pass)
        report($sformatf("passthrough %b, want %b", got.pass, want.pass));
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [2:0]  opcode = '0;
  logic [3:0]  reg_index = '0;
  logic [7:0]  write_data = '0;
  logic [9:0]  pixel_x = '0;
  logic [8:0]  pixel_y = '0;
  logic [7:0]  fetched_byte = '0;
  logic        done;
  logic [7:0]  read_data;
  logic [19:0] fb_offset;
  logic [23:0] rgb;
  logic        layer_active;
  logic        passthrough;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  scanout_scoreboard sb = new();
  int idle_pct = 0;
  int items_sent = 0;

  bitmap_layer_palette_scanout_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .reg_index(reg_index), .write_data(write_data),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .fetched_byte(fetched_byte),
    .done(done), .read_data(read_data), .fb_offset(fb_offset), .rgb(rgb),
    .layer_active(layer_active), .passthrough(passthrough),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    scan_result_t got;
    if (!rst) begin
      if (start && !busy)
        sb.note_item(opcode, reg_index, write_data, pixel_x, pixel_y, fetched_byte);
      if (done) begin
        got = '{read_data, fb_offset, rgb, layer_active, passthrough};
        sb.check_result(got);
      end
    end
  end

  task automatic send_item(logic [2:0] op, logic [3:0] r, logic [7:0] wd,
                           logic [9:0] x, logic [8:0] y, logic [7:0] fb);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    reg_index <= r;
    write_data <= wd;
    pixel_x <= x;
    pixel_y <= y;
    fetched_byte <= fb;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Hold the sender until every outstanding result is back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_SWITCH;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_switch(logic v);
    logic [31:0] rdata;
    apb_access(1'b1, {31'b0, v}, rdata);
    sb.set_switch(v);
    @(posedge clk);
    apb_access(1'b0, '0, rdata);
    if (rdata[0] !== v)
      sb.report($sformatf("master_switch reads %b, want %b", rdata[0], v));
    @(posedge clk);
  endtask

  function automatic logic [9:0] rand_x();
    return ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                       : 10'($urandom_range(0, 639));
  endfunction

  function automatic logic [8:0] rand_y();
    return ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                       : 9'($urandom_range(0, 479));
  endfunction

  task automatic send_pixel(logic [2:0] op);
    send_item(op, 4'($urandom), 8'($urandom), rand_x(), rand_y(), 8'($urandom));
  endtask

  task automatic send_write(logic [3:0] r, logic [7:0] wd);
    send_item(blps_pkg::OP_REG_WRITE, r, wd, rand_x(), rand_y(), 8'($urandom));
  endtask

  // Mostly well-formed traffic: palette loads, mode changes, frame starts and scanout.
  task automatic random_step();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_write(blps_pkg::REG_CURSOR, 8'($urandom));
      n = $urandom_range(1, 6);
      repeat (n) begin
        send_write(blps_pkg::REG_PAL_LO, 8'($urandom));
        send_write(blps_pkg::REG_PAL_HI, 8'($urandom));
      end
    end else if (pick < 20) begin
      send_write(blps_pkg::REG_CTRL, 8'($urandom));
    end else if (pick < 27) begin
      send_write(4'($urandom_range(blps_pkg::REG_BASE_LO, blps_pkg::REG_BASE_HI)),
                 8'($urandom));
      if ($urandom_range(0, 1)) send_pixel(blps_pkg::OP_FRAME);
    end else if (pick < 37) begin
      send_item(blps_pkg::OP_REG_READ, 4'($urandom), 8'($urandom), rand_x(), rand_y(),
                8'($urandom));
    end else if (pick < 60) begin
      send_pixel(blps_pkg::OP_PIX_ADDR);
    end else if (pick < 90) begin
      send_pixel(blps_pkg::OP_PIX_COLOR);
    end else if (pick < 95) begin
      send_write(4'($urandom), 8'($urandom));
    end else begin
      send_pixel(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
    end
  endtask

  initial begin
    int pct [4] = '{0, 82, 0, 24};
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, switch off: resets, base masking, wrap cases, palette cursor wrap.
    send_item(blps_pkg::OP_REG_READ, blps_pkg::REG_CTRL, 8'h00, 10'd0, 9'd0, 8'h00);
    send_item(blps_pkg::OP_REG_READ, blps_pkg::REG_ID, 8'h00, 10'd0, 9'd0, 8'h00);
    send_write(blps_pkg::REG_CTRL, 8'hFF);
    send_write(blps_pkg::REG_BASE_LO, 8'hFF);
    send_write(blps_pkg::REG_BASE_MD, 8'hFF);
    send_write(blps_pkg::REG_BASE_HI, 8'hFF);
    send_item(blps_pkg::OP_REG_READ, blps_pkg::REG_BASE_LO, 8'h00, 10'd0, 9'd0, 8'h00);
    send_item(blps_pkg::OP_REG_READ, blps_pkg::REG_BASE_MD, 8'h00, 10'd0, 9'd0, 8'h00);
    send_item(blps_pkg::OP_REG_READ, blps_pkg::REG_BASE_HI, 8'h00, 10'd0, 9'd0, 8'h00);
    send_item(blps_pkg::OP_FRAME, blps_pkg::REG_CTRL, 8'h00, 10'd0, 9'd0, 8'h00);
    send_item(blps_pkg::OP_PIX_ADDR, blps_pkg::REG_CTRL, 8'h00, 10'd639, 9'd479, 8'h00);
    send_write(blps_pkg::REG_CTRL, 8'h03);
    send_item(blps_pkg::OP_PIX_ADDR, REG_LAST, 8'hFF, 10'd1023, 9'd511, 8'hFF);
    send_write(blps_pkg::REG_CURSOR, 8'hFF);
    send_write(blps_pkg::REG_PAL_LO, 8'hFF);
    send_write(blps_pkg::REG_PAL_HI, 8'hFF);
    send_write(blps_pkg::REG_PAL_LO, 8'h5A);
    send_write(blps_pkg::REG_PAL_HI, 8'h03);
    send_item(blps_pkg::OP_PIX_COLOR, blps_pkg::REG_CTRL, 8'h00, 10'd0, 9'd0, 8'hFF);
    send_item(blps_pkg::OP_PIX_COLOR, blps_pkg::REG_CTRL, 8'h00, 10'd1, 9'd0, 8'h00);
    send_write(REG_RSVD, 8'hFF);
    send_write(blps_pkg::REG_ID, 8'hFF);
    send_item(blps_pkg::OP_REG_READ, REG_RSVD, 8'h00, 10'd0, 9'd0, 8'h00);
    send_item(OP_SPARE_LO, blps_pkg::REG_CTRL, 8'hFF, 10'd639, 9'd479, 8'hFF);
    send_item(OP_SPARE_HI, REG_LAST, 8'h00, 10'd0, 9'd0, 8'h00);
    drain();

    // Switch on: ID value, active layer in the alternate mode, nibble select.
    set_switch(1'b1);
    send_item(blps_pkg::OP_REG_READ, blps_pkg::REG_ID, 8'h00, 10'd0, 9'd0, 8'h00);
    send_write(blps_pkg::REG_CTRL, 8'h05);
    send_item(blps_pkg::OP_PIX_COLOR, blps_pkg::REG_CTRL, 8'h00, 10'd0, 9'd0, 8'hF0);
    send_item(blps_pkg::OP_PIX_COLOR, blps_pkg::REG_CTRL, 8'h00, 10'd1, 9'd0, 8'hF0);
    drain();

    for (int p = 0; p < 4; p++) begin
      set_switch(p % 2 == 0);
      idle_pct = pct[p];
      target = items_sent + RAND_ITEMS;
      while (items_sent < target) random_step();
      drain();
    end

    set_switch(1'b0);
    drain();
    if (sb.pending() > 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Covered %0d items over four idle patterns, %0d results checked,",
             items_sent, sb.checked);
    $display("with the master switch both off and on and %0d mismatches.", sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
